/* sv/c_comment_whitespace_filter_unit_assert.svh */
// Assertion macros shared by the comment and whitespace filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef C_COMMENT_WHITESPACE_FILTER_UNIT_ASSERT_SVH
`define C_COMMENT_WHITESPACE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define CWF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cwf assertion failed");

// next-cycle implication
`define CWF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cwf assertion failed");

`endif

/* sv/cwf_pkg.sv */
// Shared constants and types of the comment and whitespace filter.
// No dependencies; used by every module of the block.
`default_nettype none
package cwf_pkg;

	localparam int LINE_WIDTH   = 24;
	localparam int COLUMN_WIDTH = 16;
	localparam int BYTE_W       = 8;
	localparam int TDATA_W      = ((BYTE_W + LINE_WIDTH + COLUMN_WIDTH + 7) / 8) * 8;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_BSLASH  = 3'd2;
	localparam logic [2:0] MODE_LINECOM = 3'd3;
	localparam logic [2:0] MODE_BLOCK   = 3'd4;
	localparam logic [2:0] MODE_STAR    = 3'd5;
	localparam logic [2:0] MODE_SKIP    = 3'd6;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              endm;
	} res_t;

	// one queue entry: up to two results of one transaction
	typedef struct packed {
		res_t                    r0;
		res_t                    r1;
		logic                    two;
		logic [LINE_WIDTH-1:0]   line;
		logic [COLUMN_WIDTH-1:0] col;
	} entry_t;

endpackage
`default_nettype wire

/* sv/cwf_front.sv */
// Front end: accepts source bytes, tracks scan state and counters, builds result entries.
// Depends on cwf_pkg and the assertion macro header.
`default_nettype none
`include "c_comment_whitespace_filter_unit_assert.svh"
module cwf_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  q_ready,
	output logic                       q_wr,
	output cwf_pkg::entry_t            q_data
);

	typedef struct packed {
		logic [2:0] mode;
		logic       in_str;
		logic       sp;
		logic [7:0] prev;
	} scan_t;

	typedef struct packed {
		scan_t      st;
		logic       emit;
		logic [7:0] ch;
	} plain_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {cwf_pkg::CH_SPACE, cwf_pkg::CH_TAB, cwf_pkg::CH_VT,
			cwf_pkg::CH_FF, cwf_pkg::CH_CR};
	endfunction

	function automatic plain_t plain_byte(input scan_t s, input logic [7:0] c);
		plain_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.ch   = c;
		if (s.in_str) begin
			if (c == cwf_pkg::CH_QUOTE && s.prev != cwf_pkg::CH_BSLASH)
				r.st.in_str = 1'b0;
			r.emit = 1'b1;
		end else if (c == cwf_pkg::CH_QUOTE && s.prev != cwf_pkg::CH_BSLASH) begin
			r.st.in_str = 1'b1;
			r.emit      = 1'b1;
		end else if (c == cwf_pkg::CH_SLASH && s.prev != cwf_pkg::CH_BSLASH) begin
			r.st.mode = cwf_pkg::MODE_SLASH;
		end else if (c == cwf_pkg::CH_BSLASH) begin
			r.st.mode = cwf_pkg::MODE_BSLASH;
		end else if (c == cwf_pkg::CH_NL) begin
			r.st.sp = 1'b1;
			r.emit  = 1'b1;
		end else if (is_blank(c)) begin
			if (!s.sp) begin
				r.st.sp = 1'b1;
				r.emit  = 1'b1;
				r.ch    = cwf_pkg::CH_SPACE;
			end else begin
				r.st.mode = cwf_pkg::MODE_SKIP;
			end
		end else begin
			r.st.sp = 1'b0;
			r.emit  = 1'b1;
		end
		if (r.emit)
			r.st.prev = r.ch;
		return r;
	endfunction

	logic [2:0]                       mode_q;
	logic                             in_str_q;
	logic                             sp_q;
	logic [7:0]                       prev_q;
	logic [cwf_pkg::LINE_WIDTH-1:0]   line_q;
	logic [cwf_pkg::COLUMN_WIDTH-1:0] col_q;
	logic                             ended_q;

	scan_t                            st;
	plain_t                           pb;
	logic                             ended_n;
	logic [cwf_pkg::LINE_WIDTH-1:0]   line_n;
	logic [cwf_pkg::COLUMN_WIDTH-1:0] col_n;
	logic [7:0]                       rb [2];
	logic                             re [2];
	logic [1:0]                       n;
	logic                             acc;

	assign s_tready = q_ready;
	assign acc      = s_tvalid && q_ready;

	always_comb begin
		st      = '{mode: mode_q, in_str: in_str_q, sp: sp_q, prev: prev_q};
		pb      = '0;
		ended_n = ended_q;
		line_n  = line_q;
		col_n   = col_q;
		rb[0]   = cwf_pkg::CH_NUL;
		rb[1]   = cwf_pkg::CH_NUL;
		re[0]   = 1'b0;
		re[1]   = 1'b0;
		n       = 2'd0;
		if (ended_q) begin
			re[0] = 1'b1;
			n     = 2'd1;
		end else if (s_tlast) begin
			if (mode_q == cwf_pkg::MODE_SLASH) begin
				st.sp   = 1'b0;
				st.prev = cwf_pkg::CH_SLASH;
				rb[0]   = cwf_pkg::CH_SLASH;
				n       = 2'd1;
			end else if (mode_q == cwf_pkg::MODE_BSLASH) begin
				st.prev = cwf_pkg::CH_BSLASH;
				rb[0]   = cwf_pkg::CH_BSLASH;
				n       = 2'd1;
			end
			st.mode     = cwf_pkg::MODE_NORMAL;
			ended_n     = 1'b1;
			rb[n[0]]    = cwf_pkg::CH_NUL;
			re[n[0]]    = 1'b1;
			n           = 2'(n + 2'd1);
		end else begin
			if (s_tdata == cwf_pkg::CH_NL) begin
				if (line_q != '1)
					line_n = line_q + 1'b1;
				col_n = '0;
			end else if (col_q != '1) begin
				col_n = col_q + 1'b1;
			end
			case (mode_q)
				cwf_pkg::MODE_SLASH: begin
					if (s_tdata == cwf_pkg::CH_SLASH) begin
						st.mode = cwf_pkg::MODE_LINECOM;
					end else if (s_tdata == cwf_pkg::CH_STAR) begin
						st.mode = cwf_pkg::MODE_BLOCK;
					end else begin
						st.mode = cwf_pkg::MODE_NORMAL;
						st.sp   = 1'b0;
						st.prev = cwf_pkg::CH_SLASH;
						rb[0]   = cwf_pkg::CH_SLASH;
						n       = 2'd1;
						pb      = plain_byte(st, s_tdata);
						st      = pb.st;
						if (pb.emit) begin
							rb[1] = pb.ch;
							n     = 2'd2;
						end
					end
				end
				cwf_pkg::MODE_BSLASH: begin
					st.mode = cwf_pkg::MODE_NORMAL;
					if (s_tdata == cwf_pkg::CH_NL) begin
						if (!st.sp) begin
							st.sp   = 1'b1;
							st.prev = cwf_pkg::CH_SPACE;
							rb[0]   = cwf_pkg::CH_SPACE;
							n       = 2'd1;
						end
					end else begin
						st.prev = cwf_pkg::CH_BSLASH;
						rb[0]   = cwf_pkg::CH_BSLASH;
						n       = 2'd1;
						pb      = plain_byte(st, s_tdata);
						st      = pb.st;
						if (pb.emit) begin
							rb[1] = pb.ch;
							n     = 2'd2;
						end
					end
				end
				cwf_pkg::MODE_LINECOM: begin
					if (s_tdata == cwf_pkg::CH_NL) begin
						st.mode = cwf_pkg::MODE_NORMAL;
						st.prev = s_tdata;
						rb[0]   = s_tdata;
						n       = 2'd1;
					end
				end
				cwf_pkg::MODE_BLOCK: begin
					if (s_tdata == cwf_pkg::CH_STAR)
						st.mode = cwf_pkg::MODE_STAR;
				end
				cwf_pkg::MODE_STAR: begin
					if (s_tdata == cwf_pkg::CH_SLASH) begin
						st.mode = cwf_pkg::MODE_NORMAL;
						if (!st.sp) begin
							st.sp   = 1'b1;
							st.prev = cwf_pkg::CH_SPACE;
							rb[0]   = cwf_pkg::CH_SPACE;
							n       = 2'd1;
						end
					end else if (s_tdata != cwf_pkg::CH_STAR) begin
						st.mode = cwf_pkg::MODE_BLOCK;
					end
				end
				cwf_pkg::MODE_SKIP: begin
					if (!(is_blank(s_tdata) || s_tdata == cwf_pkg::CH_NL)) begin
						st.mode = cwf_pkg::MODE_NORMAL;
						pb      = plain_byte(st, s_tdata);
						st      = pb.st;
						if (pb.emit) begin
							rb[0] = pb.ch;
							n     = 2'd1;
						end
					end
				end
				default: begin
					st.mode = cwf_pkg::MODE_NORMAL;
					pb      = plain_byte(st, s_tdata);
					st      = pb.st;
					if (pb.emit) begin
						rb[0] = pb.ch;
						n     = 2'd1;
					end
				end
			endcase
		end
	end

	assign q_wr           = acc && (n != 2'd0);
	assign q_data.r0.ch   = rb[0];
	assign q_data.r0.endm = re[0];
	assign q_data.r1.ch   = rb[1];
	assign q_data.r1.endm = re[1];
	assign q_data.two     = (n == 2'd2);
	assign q_data.line    = line_n;
	assign q_data.col     = col_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cwf_pkg::MODE_NORMAL;
			in_str_q <= 1'b0;
			sp_q     <= 1'b1;
			prev_q   <= cwf_pkg::CH_NUL;
			line_q   <= cwf_pkg::LINE_WIDTH'(1);
			col_q    <= '0;
			ended_q  <= 1'b0;
		end else if (acc) begin
			mode_q   <= st.mode;
			in_str_q <= st.in_str;
			sp_q     <= st.sp;
			prev_q   <= st.prev;
			line_q   <= line_n;
			col_q    <= col_n;
			ended_q  <= ended_n;
		end
	end

	`CWF_ASSERT_IMP(a_ended_normal, clk, arst_n, ended_q, mode_q == cwf_pkg::MODE_NORMAL)
	`CWF_ASSERT_IMP(a_line_nonzero, clk, arst_n, 1'b1, line_q != '0)

endmodule
`default_nettype wire

/* sv/cwf_fifo.sv */
// Short queue of result entries between the front end and the output stage.
// Depends on cwf_pkg and the assertion macro header.
`default_nettype none
`include "c_comment_whitespace_filter_unit_assert.svh"
module cwf_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire cwf_pkg::entry_t  wdata,
	output logic                  ready,
	input  wire logic             rd,
	output cwf_pkg::entry_t       rdata,
	output logic                  rvalid
);

	cwf_pkg::entry_t                mem_q [cwf_pkg::FIFO_DEPTH];
	logic [cwf_pkg::FIFO_AW-1:0]   wp_q;
	logic [cwf_pkg::FIFO_AW-1:0]   rp_q;
	logic [cwf_pkg::FIFO_AW:0]     count_q;

	assign ready  = count_q != (cwf_pkg::FIFO_AW + 1)'(cwf_pkg::FIFO_DEPTH);
	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

	`CWF_ASSERT_IMP(a_no_overflow, clk, arst_n, wr, ready)
	`CWF_ASSERT_IMP(a_no_underflow, clk, arst_n, rd, rvalid)

endmodule
`default_nettype wire

/* sv/cwf_back.sv */
// Output stage: splits queue entries into single results and holds them for the master side.
// Depends on cwf_pkg and the assertion macro header.
`default_nettype none
`include "c_comment_whitespace_filter_unit_assert.svh"
module cwf_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cwf_pkg::entry_t         head,
	input  wire logic                    head_valid,
	output logic                         pop,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [cwf_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tlast,
	output logic                         m_tuser
);

	logic                             valid_q;
	logic                             phase_q;
	logic [7:0]                       byte_q;
	logic                             endm_q;
	logic                             last_q;
	logic [cwf_pkg::LINE_WIDTH-1:0]   line_q;
	logic [cwf_pkg::COLUMN_WIDTH-1:0] col_q;

	logic          ld;
	logic          fin;
	cwf_pkg::res_t sel;

	assign ld  = head_valid && (!valid_q || m_tready);
	assign fin = !head.two || phase_q;
	assign sel = phase_q ? head.r1 : head.r0;
	assign pop = ld && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (ld) begin
			valid_q <= 1'b1;
			phase_q <= !fin;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			byte_q <= sel.ch;
			endm_q <= sel.endm;
			last_q <= fin;
			line_q <= head.line;
			col_q  <= head.col;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = cwf_pkg::TDATA_W'({col_q, line_q, byte_q});
	assign m_tlast  = last_q;
	assign m_tuser  = endm_q;

	`CWF_ASSERT_IMP(a_phase_two, clk, arst_n, phase_q, head_valid && head.two)
	`CWF_ASSERT_IMP(a_end_zero, clk, arst_n, valid_q && endm_q, byte_q == cwf_pkg::CH_NUL)
	`CWF_ASSERT_NXT(a_second_follows, clk, arst_n, ld && !fin, valid_q && !last_q)

endmodule
`default_nettype wire

/* sv/c_comment_whitespace_filter_unit.sv */
// With the queue empty and the output register free, a result enters the result queue as its
// input transaction is accepted, then is loaded into the output register for the master side.
// Input: one transaction per cycle while s_tready is high; a transaction with two results is
// presented as two output results in turn, and the four-entry result queue absorbs the difference.
// s_tready falls only when the result queue is full.
// Reset (arst_n low, asynchronous): scanner to normal mode, line 1, column 0, queue empty.
`default_nettype none
module c_comment_whitespace_filter_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [7:0]              s_tdata,  // [7:0] in_byte
	input  wire logic                    s_tlast,  // end_of_input
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [cwf_pkg::TDATA_W-1:0]  m_tdata,  // out_byte, line_number, column_number
	output logic                         m_tlast,  // last_of_run
	output logic                         m_tuser   // end_mark
);

	logic            q_ready;
	logic            q_wr;
	cwf_pkg::entry_t q_wdata;
	cwf_pkg::entry_t q_head;
	logic            q_valid;
	logic            q_pop;

	cwf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_ready  (q_ready),
		.q_wr     (q_wr),
		.q_data   (q_wdata)
	);

	cwf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.ready  (q_ready),
		.rd     (q_pop),
		.rdata  (q_head),
		.rvalid (q_valid)
	);

	cwf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_valid),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

/* verif/tb_c_comment_whitespace_filter_unit.sv */
// Self-checking testbench for c_comment_whitespace_filter_unit: feeds C-like text
// with random stalls on both streams and checks every filtered result against a scanner model.
// Depends on cwf_pkg and the c_comment_whitespace_filter_unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_c_comment_whitespace_filter_unit;

	localparam int NUM_ITEMS   = 1950;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} src_item_t;

	typedef struct packed {
		logic [7:0]                       ch;
		logic                             endm;
		logic                             last;
		logic [cwf_pkg::LINE_WIDTH-1:0]   line;
		logic [cwf_pkg::COLUMN_WIDTH-1:0] col;
	} filt_out_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata  = 8'h00;
	logic                         s_tlast  = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [cwf_pkg::TDATA_W-1:0]  m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;

	c_comment_whitespace_filter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	src_item_t src_q[$];
	filt_out_t filtered_q[$];
	int        n_total;
	int        n_acc;
	int        n_err;
	int        stall_cyc;
	int        src_gap;
	int        dst_gap;
	int        hold_left;
	bit        hold_done;
	bit        s_took;

	// scanner state
	logic [2:0]                       scan_md;
	logic                             in_str;
	logic                             sp_flag;
	logic [7:0]                       prev_out;
	logic [cwf_pkg::LINE_WIDTH-1:0]   line_cnt;
	logic [cwf_pkg::COLUMN_WIDTH-1:0] col_cnt;
	logic                             eos;

	initial begin
		scan_md  = cwf_pkg::MODE_NORMAL;
		in_str   = 1'b0;
		sp_flag  = 1'b1;
		prev_out = cwf_pkg::CH_NUL;
		line_cnt = cwf_pkg::LINE_WIDTH'(1);
		col_cnt  = '0;
		eos      = 1'b0;
	end

	function automatic bit is_blank(logic [7:0] c);
		return c inside {cwf_pkg::CH_SPACE, cwf_pkg::CH_TAB, cwf_pkg::CH_VT,
			cwf_pkg::CH_FF, cwf_pkg::CH_CR};
	endfunction

	task automatic emit(logic [7:0] c, logic e);
		filtered_q.push_back('{ch: c, endm: e, last: 1'b0, line: line_cnt, col: col_cnt});
		if (!e)
			prev_out = c;
	endtask

	task automatic join_space();
		if (!sp_flag) begin
			sp_flag = 1'b1;
			emit(cwf_pkg::CH_SPACE, 1'b0);
		end
	endtask

	task automatic take_plain(logic [7:0] c);
		if (in_str) begin
			if (c == cwf_pkg::CH_QUOTE && prev_out != cwf_pkg::CH_BSLASH)
				in_str = 1'b0;
			emit(c, 1'b0);
		end else if (c == cwf_pkg::CH_QUOTE && prev_out != cwf_pkg::CH_BSLASH) begin
			in_str = 1'b1;
			emit(c, 1'b0);
		end else if (c == cwf_pkg::CH_SLASH && prev_out != cwf_pkg::CH_BSLASH) begin
			scan_md = cwf_pkg::MODE_SLASH;
		end else if (c == cwf_pkg::CH_BSLASH) begin
			scan_md = cwf_pkg::MODE_BSLASH;
		end else if (c == cwf_pkg::CH_NL) begin
			sp_flag = 1'b1;
			emit(c, 1'b0);
		end else if (is_blank(c)) begin
			if (!sp_flag) begin
				sp_flag = 1'b1;
				emit(cwf_pkg::CH_SPACE, 1'b0);
			end else begin
				scan_md = cwf_pkg::MODE_SKIP;
			end
		end else begin
			sp_flag = 1'b0;
			emit(c, 1'b0);
		end
	endtask

	task automatic scan_byte(logic [7:0] c, logic endin);
		int        n0;
		filt_out_t r;
		n0 = filtered_q.size();
		if (eos) begin
			emit(cwf_pkg::CH_NUL, 1'b1);
		end else if (endin) begin
			if (scan_md == cwf_pkg::MODE_SLASH) begin
				sp_flag = 1'b0;
				emit(cwf_pkg::CH_SLASH, 1'b0);
			end else if (scan_md == cwf_pkg::MODE_BSLASH) begin
				emit(cwf_pkg::CH_BSLASH, 1'b0);
			end
			scan_md = cwf_pkg::MODE_NORMAL;
			eos = 1'b1;
			emit(cwf_pkg::CH_NUL, 1'b1);
		end else begin
			if (c == cwf_pkg::CH_NL) begin
				if (line_cnt != '1)
					line_cnt++;
				col_cnt = '0;
			end else if (col_cnt != '1) begin
				col_cnt++;
			end
			case (scan_md)
				cwf_pkg::MODE_SLASH: begin
					if (c == cwf_pkg::CH_SLASH) begin
						scan_md = cwf_pkg::MODE_LINECOM;
					end else if (c == cwf_pkg::CH_STAR) begin
						scan_md = cwf_pkg::MODE_BLOCK;
					end else begin
						scan_md = cwf_pkg::MODE_NORMAL;
						sp_flag = 1'b0;
						emit(cwf_pkg::CH_SLASH, 1'b0);
						take_plain(c);
					end
				end
				cwf_pkg::MODE_BSLASH: begin
					scan_md = cwf_pkg::MODE_NORMAL;
					if (c == cwf_pkg::CH_NL) begin
						join_space();
					end else begin
						emit(cwf_pkg::CH_BSLASH, 1'b0);
						take_plain(c);
					end
				end
				cwf_pkg::MODE_LINECOM: begin
					if (c == cwf_pkg::CH_NL) begin
						scan_md = cwf_pkg::MODE_NORMAL;
						emit(c, 1'b0);
					end
				end
				cwf_pkg::MODE_BLOCK: begin
					if (c == cwf_pkg::CH_STAR)
						scan_md = cwf_pkg::MODE_STAR;
				end
				cwf_pkg::MODE_STAR: begin
					if (c == cwf_pkg::CH_SLASH) begin
						scan_md = cwf_pkg::MODE_NORMAL;
						join_space();
					end else if (c != cwf_pkg::CH_STAR) begin
						scan_md = cwf_pkg::MODE_BLOCK;
					end
				end
				cwf_pkg::MODE_SKIP: begin
					if (!(is_blank(c) || c == cwf_pkg::CH_NL)) begin
						scan_md = cwf_pkg::MODE_NORMAL;
						take_plain(c);
					end
				end
				default: begin
					scan_md = cwf_pkg::MODE_NORMAL;
					take_plain(c);
				end
			endcase
		end
		if (filtered_q.size() > n0) begin
			r = filtered_q.pop_back();
			r.last = 1'b1;
			filtered_q.push_back(r);
		end
	endtask

	// stimulus helpers
	task automatic add_item(logic [7:0] b, logic e);
		src_q.push_back('{b: b, e: e});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 11))
			0: return cwf_pkg::CH_SLASH;
			1: return cwf_pkg::CH_STAR;
			2: return cwf_pkg::CH_BSLASH;
			3: return cwf_pkg::CH_QUOTE;
			4: return cwf_pkg::CH_SPACE;
			5: return cwf_pkg::CH_NL;
			default: return 8'($urandom_range(33, 126));
		endcase
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 5))
			0: return cwf_pkg::CH_TAB;
			1: return cwf_pkg::CH_VT;
			2: return cwf_pkg::CH_FF;
			3: return cwf_pkg::CH_CR;
			4: return cwf_pkg::CH_NL;
			default: return cwf_pkg::CH_SPACE;
		endcase
	endfunction

	task automatic add_fragment();
		int n;
		n = $urandom_range(0, 8);
		case ($urandom_range(0, 15))
			4: for (int i = 0; i <= n % 4; i++) add_item(blank_byte(), 1'b0);
			5: begin
				add_text("//");
				for (int i = 0; i < n; i++) add_item(text_byte(), 1'b0);
				add_item(cwf_pkg::CH_NL, 1'b0);
			end
			6: begin
				add_text("/*");
				for (int i = 0; i < n; i++)
					add_item($urandom_range(0, 2) == 0 ? cwf_pkg::CH_STAR : text_byte(), 1'b0);
				add_text("*/");
			end
			7: begin
				add_item(cwf_pkg::CH_QUOTE, 1'b0);
				for (int i = 0; i < n % 7; i++) add_item(text_byte(), 1'b0);
				add_item(cwf_pkg::CH_QUOTE, 1'b0);
			end
			8: begin
				add_item(cwf_pkg::CH_BSLASH, 1'b0);
				add_item($urandom_range(0, 2) != 0 ? cwf_pkg::CH_NL : text_byte(), 1'b0);
			end
			9: begin
				add_item(cwf_pkg::CH_SLASH, 1'b0);
				add_item(text_byte(), 1'b0);
			end
			10: for (int i = 0; i <= n % 3; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
			11: begin
				add_item(cwf_pkg::CH_BSLASH, 1'b0);
				add_item(cwf_pkg::CH_QUOTE, 1'b0);
			end
			12: add_item(cwf_pkg::CH_NL, 1'b0);
			13: add_text("**/");
			default: for (int i = 0; i <= n % 6; i++) add_item(text_byte(), 1'b0);
		endcase
	endtask

	function automatic bit no_idle();
		return (n_acc + CALM_TAIL >= n_total) || (((n_acc >> 7) % 3) == 2);
	endfunction

	// source side
	always @(negedge clk) begin
		src_item_t it;
		if (arst_n && (!s_tvalid || s_took)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (src_q.size() > 0) begin
				it = src_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= it.b;
				s_tlast  <= it.e;
				if (!no_idle() && $urandom_range(0, 11) == 0)
					src_gap = $urandom_range(1, 15);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && n_acc >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (dst_gap > 0) begin
			dst_gap--;
			m_tready <= 1'b0;
		end else if (!no_idle() && $urandom_range(0, 15) == 0) begin
			dst_gap = $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		filt_out_t got;
		filt_out_t want;
		if (arst_n) begin
			s_took = s_tvalid && s_tready;
			if (s_took) begin
				scan_byte(s_tdata, s_tlast);
				n_acc++;
			end
			if (m_tvalid && m_tready) begin
				got.ch   = m_tdata[cwf_pkg::BYTE_W-1:0];
				got.line = m_tdata[cwf_pkg::BYTE_W +: cwf_pkg::LINE_WIDTH];
				got.col  = m_tdata[cwf_pkg::BYTE_W + cwf_pkg::LINE_WIDTH +: cwf_pkg::COLUMN_WIDTH];
				got.endm = m_tuser;
				got.last = m_tlast;
				if (filtered_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result ch=%h end=%b last=%b line=%0d col=%0d",
						$time, got.ch, got.endm, got.last, got.line, got.col);
				end else begin
					want = filtered_q.pop_front();
					if (got.ch !== want.ch || got.endm !== want.endm || got.last !== want.last ||
							got.line !== want.line || got.col !== want.col) begin
						n_err++;
						$display({"%0t: mismatch expected ch=%h end=%b last=%b line=%0d col=%0d",
							" actual ch=%h end=%b last=%b line=%0d col=%0d"}, $time,
							want.ch, want.endm, want.last, want.line, want.col,
							got.ch, got.endm, got.last, got.line, got.col);
					end
				end
			end
			if (s_took || (m_tvalid && m_tready))
				stall_cyc = 0;
			else
				stall_cyc++;
			if (stall_cyc >= STALL_LIMIT) begin
				$display("%0t: timeout, no transaction for %0d cycles", $time, stall_cyc);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		// extremes, held slash, line comment, block comment with extra stars
		add_item(cwf_pkg::CH_NUL, 1'b0);
		add_item(8'hFF, 1'b0);
		add_text("a/b//x\n/***/");
		// blanks while skipping, backslash-newline join, escaped quote in a string
		add_item(cwf_pkg::CH_TAB, 1'b0);
		add_item(cwf_pkg::CH_VT, 1'b0);
		add_item(cwf_pkg::CH_FF, 1'b0);
		add_item(cwf_pkg::CH_CR, 1'b0);
		add_item(cwf_pkg::CH_NL, 1'b0);
		add_text("\\\n\"\\\"\"");

		while (src_q.size() < NUM_ITEMS)
			add_fragment();

		// stream end from a random scanner state, then items past the end
		case ($urandom_range(0, 4))
			0: add_item(cwf_pkg::CH_SLASH, 1'b0);
			1: add_item(cwf_pkg::CH_BSLASH, 1'b0);
			2: add_text("/*");
			3: add_item(cwf_pkg::CH_SPACE, 1'b0);
			default: add_item(text_byte(), 1'b0);
		endcase
		add_item(8'($urandom_range(0, 255)), 1'b1);
		for (int i = 0; i < 4; i++)
			add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		n_total = src_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_acc < n_total || filtered_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/cwf_pkg.sv
sv/cwf_front.sv
sv/cwf_fifo.sv
sv/cwf_back.sv
sv/c_comment_whitespace_filter_unit.sv
verif/tb_c_comment_whitespace_filter_unit.sv
